// File: rtl/core/mlr_pkg.sv
package mlr_pkg;

    localparam int CoordBits = 12;
    localparam int DecBits   = CoordBits + 3;

    typedef logic [CoordBits-1:0]      t_coord;
    typedef logic signed [DecBits-1:0] t_dec;
    typedef logic [2:0]                t_octant;
    typedef logic                      t_kind;

    localparam t_kind KIND_LOAD = 1'b0;
    localparam t_kind KIND_STEP = 1'b1;

    localparam t_octant OCT_X_POS_Y_POS_SHALLOW = 3'd0;
    localparam t_octant OCT_Y_POS_X_POS_STEEP   = 3'd1;
    localparam t_octant OCT_Y_POS_X_NEG_STEEP   = 3'd2;
    localparam t_octant OCT_X_NEG_Y_POS_SHALLOW = 3'd3;
    localparam t_octant OCT_X_NEG_Y_NEG_SHALLOW = 3'd4;
    localparam t_octant OCT_Y_NEG_X_NEG_STEEP   = 3'd5;
    localparam t_octant OCT_Y_NEG_X_POS_STEEP   = 3'd6;
    localparam t_octant OCT_X_POS_Y_NEG_SHALLOW = 3'd7;

    // Per-octant properties, bit n belongs to octant n
    localparam logic [7:0] OctMajorY   = 8'b0110_0110;
    localparam logic [7:0] OctMajorPos = 8'b1000_0111;
    localparam logic [7:0] OctMinorPos = 8'b0100_1011;
    localparam logic [7:0] OctTestGt   = 8'b1010_1000;

    typedef struct packed {
        t_kind  kind;
        t_coord x_start;
        t_coord y_start;
        t_coord x_end;
        t_coord y_end;
    } t_in_item;

    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        logic   last;
    } t_out_item;

    // Classified command passed from the front end to the stepper
    typedef struct packed {
        t_kind   kind;
        t_coord  x_start;
        t_coord  y_start;
        t_octant octant;
        t_coord  major_end;
        t_dec    decision;
        t_dec    inc_minor_step;
        t_dec    inc_major_only;
    } t_cmd;

endpackage

// File: rtl/core/mlr_queue.sv
module mlr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntBits = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   r_mem [DEPTH];
    logic [PtrBits-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrBits-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntBits-1:0] r_count, n_count;
    logic               wr_en;
    logic               rd_en;

    assign o_full  = (r_count == CntBits'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PtrBits'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PtrBits'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + CntBits'(wr_en) - CntBits'(rd_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: rtl/core/mlr_front.sv
module mlr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mlr_pkg::t_in_item i_data,
    output logic              o_full,
    output logic              o_cmd_valid,
    output mlr_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_full
);
    import mlr_pkg::*;

    localparam int DiffBits = CoordBits + 1;

    logic                       r_valid, n_valid;
    t_cmd                       r_cmd, n_cmd;
    t_cmd                       setup;
    logic                       take;
    logic signed [DiffBits-1:0] dx, dy;
    t_coord                     adx, ady;
    logic                       steep, xpos, ypos;
    t_dec                       dx_e, dy_e, dx2, dy2;

    assign o_full      = r_valid && i_cmd_full;
    assign take        = i_push && !o_full;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    // Classify the line and work out the initial decision terms
    always_comb begin
        dx    = $signed({1'b0, i_data.x_end}) - $signed({1'b0, i_data.x_start});
        dy    = $signed({1'b0, i_data.y_end}) - $signed({1'b0, i_data.y_start});
        adx   = dx[DiffBits-1] ? CoordBits'(-dx) : dx[CoordBits-1:0];
        ady   = dy[DiffBits-1] ? CoordBits'(-dy) : dy[CoordBits-1:0];
        steep = ady > adx;
        xpos  = !dx[DiffBits-1] && (dx != '0);
        ypos  = !dy[DiffBits-1] && (dy != '0);
        dx_e  = DecBits'(dx);
        dy_e  = DecBits'(dy);
        dx2   = dx_e <<< 1;
        dy2   = dy_e <<< 1;

        setup         = '0;
        setup.kind    = i_data.kind;
        setup.x_start = i_data.x_start;
        setup.y_start = i_data.y_start;
        if (!steep) begin
            setup.major_end = i_data.x_end;
            if (xpos && ypos) begin
                setup.octant         = OCT_X_POS_Y_POS_SHALLOW;
                setup.decision       = dx_e - dy2;
                setup.inc_minor_step = dx2 - dy2;
                setup.inc_major_only = -dy2;
            end else if (xpos) begin
                setup.octant         = OCT_X_POS_Y_NEG_SHALLOW;
                setup.decision       = -dx_e - dy2;
                setup.inc_minor_step = -dx2 - dy2;
                setup.inc_major_only = -dy2;
            end else if (ypos) begin
                setup.octant         = OCT_X_NEG_Y_POS_SHALLOW;
                setup.decision       = dx_e + dy2;
                setup.inc_minor_step = dx2 + dy2;
                setup.inc_major_only = dy2;
            end else begin
                setup.octant         = OCT_X_NEG_Y_NEG_SHALLOW;
                setup.decision       = -dx_e + dy2;
                setup.inc_minor_step = -dx2 + dy2;
                setup.inc_major_only = dy2;
            end
        end else begin
            setup.major_end = i_data.y_end;
            if (xpos && ypos) begin
                setup.octant         = OCT_Y_POS_X_POS_STEEP;
                setup.decision       = dy_e - dx2;
                setup.inc_minor_step = dy2 - dx2;
                setup.inc_major_only = -dx2;
            end else if (xpos) begin
                setup.octant         = OCT_Y_NEG_X_POS_STEEP;
                setup.decision       = -dx2 - dy_e;
                setup.inc_minor_step = -dx2 - dy2;
                setup.inc_major_only = -dx2;
            end else if (ypos) begin
                setup.octant         = OCT_Y_POS_X_NEG_STEEP;
                setup.decision       = dx2 + dy_e;
                setup.inc_minor_step = dx2 + dy2;
                setup.inc_major_only = dx2;
            end else begin
                setup.octant         = OCT_Y_NEG_X_NEG_STEEP;
                setup.decision       = -dx2 + dy_e;
                setup.inc_minor_step = -dx2 + dy2;
                setup.inc_major_only = -dx2;
            end
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_cmd   = r_cmd;
        if (take) begin
            n_valid = 1'b1;
            n_cmd   = setup;
        end else if (r_valid && !i_cmd_full) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

endmodule

// File: rtl/core/mlr_back.sv
module mlr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  mlr_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    input  logic               i_out_full,
    output logic               o_out_push,
    output mlr_pkg::t_out_item o_out_item
);
    import mlr_pkg::*;

    t_coord  r_cursor_x, n_cursor_x;
    t_coord  r_cursor_y, n_cursor_y;
    t_dec    r_decision, n_decision;
    t_coord  r_major_end, n_major_end;
    t_octant r_octant, n_octant;
    t_dec    r_inc_minor, n_inc_minor;
    t_dec    r_inc_major, n_inc_major;
    logic    r_active, n_active;

    logic    is_step;
    logic    emits;
    logic    go;
    logic    major_y;
    logic    is_last;
    logic    minor_moves;
    t_coord  major;

    assign is_step     = (i_cmd.kind == KIND_STEP);
    assign emits       = is_step && r_active;
    assign go          = i_cmd_valid && (!emits || !i_out_full);
    assign o_cmd_pop   = go;
    assign o_out_push  = go && emits;

    assign major_y     = OctMajorY[r_octant];
    assign major       = major_y ? r_cursor_y : r_cursor_x;
    assign is_last     = (major == r_major_end);
    assign minor_moves = OctTestGt[r_octant]
                       ? (!r_decision[DecBits-1] && (r_decision != '0))
                       : r_decision[DecBits-1];

    assign o_out_item.pixel_x = r_cursor_x;
    assign o_out_item.pixel_y = r_cursor_y;
    assign o_out_item.last    = is_last;

    always_comb begin
        n_cursor_x  = r_cursor_x;
        n_cursor_y  = r_cursor_y;
        n_decision  = r_decision;
        n_major_end = r_major_end;
        n_octant    = r_octant;
        n_inc_minor = r_inc_minor;
        n_inc_major = r_inc_major;
        n_active    = r_active;
        if (go && !is_step) begin
            n_cursor_x  = i_cmd.x_start;
            n_cursor_y  = i_cmd.y_start;
            n_decision  = i_cmd.decision;
            n_major_end = i_cmd.major_end;
            n_octant    = i_cmd.octant;
            n_inc_minor = i_cmd.inc_minor_step;
            n_inc_major = i_cmd.inc_major_only;
            n_active    = 1'b1;
        end else if (go && emits) begin
            // advance the minor axis on a passing decision, the major axis always
            if (minor_moves) begin
                n_decision = r_decision + r_inc_minor;
                if (major_y) begin
                    n_cursor_x = OctMinorPos[r_octant] ? r_cursor_x + 1'b1
                                                       : r_cursor_x - 1'b1;
                end else begin
                    n_cursor_y = OctMinorPos[r_octant] ? r_cursor_y + 1'b1
                                                       : r_cursor_y - 1'b1;
                end
            end else begin
                n_decision = r_decision + r_inc_major;
            end
            if (major_y) begin
                n_cursor_y = OctMajorPos[r_octant] ? r_cursor_y + 1'b1
                                                   : r_cursor_y - 1'b1;
            end else begin
                n_cursor_x = OctMajorPos[r_octant] ? r_cursor_x + 1'b1
                                                   : r_cursor_x - 1'b1;
            end
            if (is_last) begin
                n_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x  <= '0;
            r_cursor_y  <= '0;
            r_decision  <= '0;
            r_major_end <= '0;
            r_octant    <= '0;
            r_inc_minor <= '0;
            r_inc_major <= '0;
            r_active    <= 1'b0;
        end else begin
            r_cursor_x  <= n_cursor_x;
            r_cursor_y  <= n_cursor_y;
            r_decision  <= n_decision;
            r_major_end <= n_major_end;
            r_octant    <= n_octant;
            r_inc_minor <= n_inc_minor;
            r_inc_major <= n_inc_major;
            r_active    <= n_active;
        end
    end

endmodule

// File: rtl/core/midpoint_line_rasterizer.sv
// Midpoint line rasterizer, all eight octants.
// Input channel: push/full with i_data. kind 0 loads a line from its start
// and end points and gives no pixel; kind 1 asks for the next pixel of the
// loaded line. A step with no line in progress is dropped.
// Output channel: empty/pop with o_data, carrying pixel_x, pixel_y and last;
// last marks the end pixel, after which the line is finished.
// Path: a step transaction passes the setup register and the command queue;
// the stepper pushes its pixel into the result queue, where it waits for pop.
// Throughput: one transaction per cycle on both sides while no queue is full;
// each pixel needs a single add on the decision value and one compare in the
// stepper. A QUEUE_DEPTH command queue separates setup from stepping, and a
// two-entry result queue absorbs output stalls. When pop stays low the result
// queue fills, the stepper holds, the command queue fills and full rises.
// Reset clears the queues and the line state: no line is loaded.
module midpoint_line_rasterizer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  mlr_pkg::t_in_item  i_data,
    output logic               empty,
    input  logic               pop,
    output mlr_pkg::t_out_item o_data
);
    import mlr_pkg::*;

    localparam int OutDepth = 2;

    logic      front_valid;
    t_cmd      front_cmd;
    logic      cmdq_full;
    logic      cmdq_empty;
    t_cmd      cmdq_head;
    logic      cmd_pop;
    logic      outq_full;
    logic      out_push;
    t_out_item out_item;

    mlr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data      (i_data),
        .o_full      (full),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd),
        .i_cmd_full  (cmdq_full)
    );

    mlr_queue #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_cmd),
        .o_full  (cmdq_full),
        .i_pop   (cmd_pop),
        .o_data  (cmdq_head),
        .o_empty (cmdq_empty)
    );

    mlr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!cmdq_empty),
        .i_cmd       (cmdq_head),
        .o_cmd_pop   (cmd_pop),
        .i_out_full  (outq_full),
        .o_out_push  (out_push),
        .o_out_item  (out_item)
    );

    mlr_queue #(
        .WIDTH ($bits(t_out_item)),
        .DEPTH (OutDepth)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_item),
        .o_full  (outq_full),
        .i_pop   (pop),
        .o_data  (o_data),
        .o_empty (empty)
    );

endmodule
